@@ sv/bsst_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the bounded signed score table.
// No dependencies; used by every module of the block.
package bsst_pkg;

   localparam logic [1:0] REQ_ADD      = 2'd0;
   localparam logic [1:0] REQ_LOOKUP   = 2'd1;
   localparam logic [1:0] REQ_TRIM     = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   localparam logic [2:0] OC_UNCHANGED = 3'd0;
   localparam logic [2:0] OC_UPDATED   = 3'd1;
   localparam logic [2:0] OC_REMOVED   = 3'd2;
   localparam logic [2:0] OC_CREATED   = 3'd3;
   localparam logic [2:0] OC_CREATED_EV = 3'd4;
   localparam logic [2:0] OC_DROPPED   = 3'd5;
   localparam logic [2:0] OC_INVALID   = 3'd6;
   localparam logic [2:0] OC_TRIMMED   = 3'd7;

   localparam logic [1:0] CSR_ENTRY_LIMIT = 2'd0;
   localparam logic [1:0] CSR_VALUE_MAX   = 2'd1;
   localparam logic [1:0] CSR_DELTA_MAX   = 2'd2;
   localparam logic [1:0] CSR_OWN_ID      = 2'd3;

   typedef struct packed {
      logic [15:0]        key;
      logic signed [15:0] score;
   } entry_type;

   typedef struct packed {
      logic [2:0]         outcome;
      logic [15:0]        evicted_key;
      logic signed [15:0] score;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [14:0] value_max;   // already forced nonzero
      logic [14:0] delta_max;   // already forced nonzero
      logic [15:0] own_id;
   } cfg_type;

   // saturate a 17-bit signed value to +-m
   function automatic logic signed [15:0] clamp_fn(input logic signed [16:0] v,
                                                   input logic [14:0] m);
      logic signed [16:0] mx;
      mx = signed'({2'b00, m});
      if (v > mx) return mx[15:0];
      if (v < -mx) return 16'(-mx);
      return v[15:0];
   endfunction

   // magnitude of a stored score (never the most negative code)
   function automatic logic [14:0] mag_fn(input logic signed [15:0] s);
      logic signed [15:0] n;
      n = -s;
      return s[15] ? n[14:0] : s[14:0];
   endfunction

endpackage

@@ sv/bsst_table.sv @@
`timescale 1ns / 1ps
// Entry storage of the score table: one write port, one registered read port.
// Depends on bsst_pkg for the entry type.
module bsst_table #(
   parameter int ENTRIES = 32
) (
   input  logic                         clock,
   input  logic [$clog2(ENTRIES)-1:0]   rd_addr,
   output bsst_pkg::entry_type          rd_data_ff,
   input  logic                         wr_en,
   input  logic [$clog2(ENTRIES)-1:0]   wr_addr,
   input  bsst_pkg::entry_type          wr_data
);
   import bsst_pkg::*;

   entry_type mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ sv/bsst_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the score table: scan, decide, shift entries, write, report.
// Depends on bsst_pkg and drives the bsst_table memory.
module bsst_ctrl #(
   parameter int ENTRIES = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_kind,
   input  logic [15:0]                    req_key,
   input  logic signed [15:0]             req_delta,
   input  logic [$clog2(ENTRIES+1)-1:0]   lim,
   input  bsst_pkg::cfg_type              cfg,
   output logic                           res_valid,
   input  logic                           res_ready,
   output bsst_pkg::result_type           res
);
   import bsst_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int CX = CW + 1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_DECIDE = 7'b0000100,
      ST_SH_RD  = 7'b0001000,
      ST_SH_WR  = 7'b0010000,
      ST_FIN    = 7'b0100000,
      ST_RESP   = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         kind_ff, kind_in;
   logic [15:0]        key_ff, key_in;
   logic signed [15:0] delta_ff, delta_in;
   logic [CW-1:0]      count_ff, count_in, count_new_ff, count_new_in;
   logic [CW-1:0]      scan_ff, scan_in, rd_idx_ff, rd_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               found_ff, found_in, eq_ff, eq_in;
   logic [CW-1:0]      idx_ff, idx_in, w_ff, w_in;
   logic signed [15:0] eqscore_ff, eqscore_in;
   logic [14:0]        wmag_ff, wmag_in;
   logic [15:0]        wkey_ff, wkey_in;
   logic [CW-1:0]      sh_j_ff, sh_j_in, sh_last_ff, sh_last_in;
   logic               sh_dec_ff, sh_dec_in;
   logic               new_wr_ff, new_wr_in;
   logic [CW-1:0]      new_pos_ff, new_pos_in;
   entry_type          new_ent_ff, new_ent_in;
   logic               more_ff, more_in;
   result_type         res_ff, res_in;

   logic [IW-1:0]      rd_addr, wr_addr;
   logic               wr_en;
   entry_type          wr_data, rd_data;

   logic [CX-1:0]      cnt_x, idx_x, w_x, lim_x;
   logic [CW-1:0]      idx_e;
   logic signed [15:0] d_c, v_c, nxt_c;
   logic signed [16:0] sum_c;
   logic [CW-1:0]      j_src;

   bsst_table #(.ENTRIES(ENTRIES)) u_table (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .rd_data_ff(rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_RESP);
   assign res       = res_ff;

   always_comb begin
      idx_e = found_ff ? idx_ff : count_ff;
      cnt_x = {1'b0, count_ff};
      idx_x = {1'b0, idx_e};
      w_x   = {1'b0, w_ff};
      lim_x = {1'b0, lim};
      d_c   = clamp_fn({delta_ff[15], delta_ff}, cfg.delta_max);
      sum_c = {eqscore_ff[15], eqscore_ff} + {d_c[15], d_c};
      nxt_c = clamp_fn(sum_c, cfg.value_max);
      v_c   = clamp_fn({d_c[15], d_c}, cfg.value_max);
      j_src = sh_dec_ff ? (sh_j_ff - 1'b1) : (sh_j_ff + 1'b1);
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      delta_in     = delta_ff;
      count_in     = count_ff;
      count_new_in = count_new_ff;
      scan_in      = scan_ff;
      rd_idx_in    = scan_ff;
      rd_vld_in    = 1'b0;
      found_in     = found_ff;
      eq_in        = eq_ff;
      idx_in       = idx_ff;
      eqscore_in   = eqscore_ff;
      w_in         = w_ff;
      wmag_in      = wmag_ff;
      wkey_in      = wkey_ff;
      sh_j_in      = sh_j_ff;
      sh_last_in   = sh_last_ff;
      sh_dec_in    = sh_dec_ff;
      new_wr_in    = new_wr_ff;
      new_pos_in   = new_pos_ff;
      new_ent_in   = new_ent_ff;
      more_in      = more_ff;
      res_in       = res_ff;
      rd_addr      = scan_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = sh_j_ff[IW-1:0];
      wr_data      = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               key_in   = req_key;
               delta_in = req_delta;
               scan_in  = '0;
               found_in = 1'b0;
               eq_in    = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one read a cycle, fold in the entry read the cycle before
            rd_vld_in = (scan_ff < count_ff);
            if (rd_vld_in) scan_in = scan_ff + 1'b1;
            if (rd_vld_ff) begin
               if (!found_ff && rd_data.key >= key_ff) begin
                  found_in   = 1'b1;
                  idx_in     = rd_idx_ff;
                  eq_in      = (rd_data.key == key_ff);
                  eqscore_in = rd_data.score;
               end
               if (rd_idx_ff == '0 || mag_fn(rd_data.score) < wmag_ff) begin
                  w_in    = rd_idx_ff;
                  wmag_in = mag_fn(rd_data.score);
                  wkey_in = rd_data.key;
               end
            end
            if (!rd_vld_in && !rd_vld_ff) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            res_in.outcome     = OC_UNCHANGED;
            res_in.evicted_key = '0;
            res_in.score       = '0;
            res_in.last        = 1'b1;
            more_in            = 1'b0;
            new_wr_in          = 1'b0;
            count_new_in       = count_ff;
            state_in           = ST_RESP;
            case (kind_ff)
               REQ_LOOKUP: begin
                  if (eq_ff) res_in.score = eqscore_ff;
               end
               REQ_TRIM: begin
                  if (cnt_x > lim_x) begin
                     res_in.outcome     = OC_TRIMMED;
                     res_in.evicted_key = wkey_ff;
                     res_in.last        = ((cnt_x - 1'b1) <= lim_x);
                     more_in            = !res_in.last;
                     count_new_in       = count_ff - 1'b1;
                     sh_j_in            = w_ff;
                     sh_last_in         = count_ff - 2'd2;
                     sh_dec_in          = 1'b0;
                     state_in = ((w_x + 2'd2) <= cnt_x) ? ST_SH_RD : ST_FIN;
                  end
               end
               REQ_ADD: begin
                  if (key_ff == '0 || key_ff == cfg.own_id) begin
                     res_in.outcome = OC_INVALID;
                  end else if (eq_ff) begin
                     if (nxt_c == eqscore_ff) begin
                        res_in.outcome = OC_UNCHANGED;
                     end else if (nxt_c == '0) begin
                        res_in.outcome = OC_REMOVED;
                        count_new_in   = count_ff - 1'b1;
                        sh_j_in        = idx_e;
                        sh_last_in     = count_ff - 2'd2;
                        sh_dec_in      = 1'b0;
                        state_in = ((idx_x + 2'd2) <= cnt_x) ? ST_SH_RD : ST_FIN;
                     end else begin
                        res_in.outcome = OC_UPDATED;
                        new_wr_in      = 1'b1;
                        new_pos_in     = idx_e;
                        new_ent_in     = '{key: key_ff, score: nxt_c};
                        state_in       = ST_FIN;
                     end
                  end else if (d_c == '0) begin
                     res_in.outcome = OC_UNCHANGED;
                  end else if (cnt_x >= lim_x) begin
                     if (mag_fn(v_c) > wmag_ff) begin
                        res_in.outcome     = OC_CREATED_EV;
                        res_in.evicted_key = wkey_ff;
                        new_wr_in          = 1'b1;
                        new_ent_in         = '{key: key_ff, score: v_c};
                        sh_j_in            = w_ff;
                        if (w_x < idx_x) begin
                           // close the gap at the victim, open one below the new key
                           new_pos_in = idx_e - 1'b1;
                           sh_last_in = idx_e - 2'd2;
                           sh_dec_in  = 1'b0;
                           state_in   = ((w_x + 2'd2) <= idx_x) ? ST_SH_RD : ST_FIN;
                        end else begin
                           new_pos_in = idx_e;
                           sh_last_in = idx_e + 1'b1;
                           sh_dec_in  = 1'b1;
                           state_in   = (w_x > idx_x) ? ST_SH_RD : ST_FIN;
                        end
                     end else begin
                        res_in.outcome = OC_DROPPED;
                     end
                  end else begin
                     res_in.outcome = OC_CREATED;
                     count_new_in   = count_ff + 1'b1;
                     new_wr_in      = 1'b1;
                     new_pos_in     = idx_e;
                     new_ent_in     = '{key: key_ff, score: v_c};
                     sh_j_in        = count_ff;
                     sh_last_in     = idx_e + 1'b1;
                     sh_dec_in      = 1'b1;
                     state_in       = (cnt_x > idx_x) ? ST_SH_RD : ST_FIN;
                  end
               end
               default: begin
                  res_in.outcome = OC_INVALID;
               end
            endcase
         end
         ST_SH_RD: begin
            rd_addr  = j_src[IW-1:0];
            state_in = ST_SH_WR;
         end
         ST_SH_WR: begin
            wr_en = 1'b1;
            if (sh_j_ff == sh_last_ff) begin
               state_in = ST_FIN;
            end else begin
               sh_j_in  = sh_dec_ff ? (sh_j_ff - 1'b1) : (sh_j_ff + 1'b1);
               state_in = ST_SH_RD;
            end
         end
         ST_FIN: begin
            wr_en    = new_wr_ff;
            wr_addr  = new_pos_ff[IW-1:0];
            wr_data  = new_ent_ff;
            count_in = count_new_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (res_ready) begin
               if (more_ff) begin
                  scan_in  = '0;
                  found_in = 1'b0;
                  eq_in    = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      delta_ff     <= delta_in;
      count_new_ff <= count_new_in;
      scan_ff      <= scan_in;
      rd_idx_ff    <= rd_idx_in;
      found_ff     <= found_in;
      eq_ff        <= eq_in;
      idx_ff       <= idx_in;
      eqscore_ff   <= eqscore_in;
      w_ff         <= w_in;
      wmag_ff      <= wmag_in;
      wkey_ff      <= wkey_in;
      sh_j_ff      <= sh_j_in;
      sh_last_ff   <= sh_last_in;
      sh_dec_ff    <= sh_dec_in;
      new_wr_ff    <= new_wr_in;
      new_pos_ff   <= new_pos_in;
      new_ent_ff   <= new_ent_in;
      more_ff      <= more_in;
      res_ff       <= res_in;
   end

endmodule

@@ sv/bounded_signed_score_table.sv @@
`timescale 1ns / 1ps
// Top level of the bounded signed score table: configuration registers,
// result output register and the bsst_ctrl sequencer. Depends on bsst_pkg.
//
// Usage:
//  - req_*: one transaction per request. tuser = req_type, tdata = {delta, key}.
//    Add (0) adjusts a key's score, lookup (1) reads it, trim (2) evicts the
//    weakest entries until the count fits entry_limit; type 3 reports invalid.
//  - rsp_*: one transaction per result; add and lookup give one, trim gives
//    one per evicted key (or one if none); tlast marks a request's last result.
//  - csr_*: register writes, always ready; write only while the block is idle.
// Sequence: a request scans the live entries one per cycle, takes a decision,
// then moves entries one at a time through the table memory, a read and then
// a write per moved entry, then writes the new entry and loads the result. A
// trim repeats that per evicted key. req_tready is high only while no request
// is in flight.
// Reset empties the table and loads limit 32, value and delta max 100, own id 0.
// When rsp_tready is low the result holds in the output register and the
// sequencer waits on the next result; no result is lost.
module bounded_signed_score_table #(
   parameter int ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] key, [31:16] delta
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] evicted_key, [31:16] score
   output logic [2:0]  rsp_tuser,   // [2:0] outcome
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bsst_pkg::*;

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int LW = (CW > 6 ? CW : 6) + 1;

   logic [5:0]    limit_ff;
   logic [14:0]   vmax_ff, dmax_ff;
   logic [15:0]   own_ff;
   logic [LW-1:0] limit_w;
   logic [CW-1:0] lim_eff;
   cfg_type       cfg;

   logic          res_valid, res_ready;
   result_type    res;
   logic          rsp_valid_ff;
   result_type    rsp_ff;

   assign csr_ready = 1'b1;

   // register file: write on handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 6'd32;
         vmax_ff  <= 15'd100;
         dmax_ff  <= 15'd100;
         own_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ENTRY_LIMIT: limit_ff <= csr_wdata[5:0];
            CSR_VALUE_MAX:   vmax_ff  <= csr_wdata[14:0];
            CSR_DELTA_MAX:   dmax_ff  <= csr_wdata[14:0];
            CSR_OWN_ID:      own_ff   <= csr_wdata;
            default:         own_ff   <= own_ff;
         endcase
      end
   end

   // effective limit: zero acts as one, anything above the table size as the size
   always_comb begin
      limit_w = LW'(limit_ff);
      if (limit_ff == '0) lim_eff = CW'(1);
      else if (limit_w > LW'(ENTRIES)) lim_eff = CW'(ENTRIES);
      else lim_eff = limit_w[CW-1:0];
      cfg.value_max = (vmax_ff == '0) ? 15'd1 : vmax_ff;
      cfg.delta_max = (dmax_ff == '0) ? 15'd1 : dmax_ff;
      cfg.own_id    = own_ff;
   end

   bsst_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_kind (req_tuser),
      .req_key  (req_tdata[15:0]),
      .req_delta(signed'(req_tdata[31:16])),
      .lim      (lim_eff),
      .cfg      (cfg),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res      (res)
   );

   // output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.score, rsp_ff.evicted_key};
   assign rsp_tuser  = rsp_ff.outcome;
   assign rsp_tlast  = rsp_ff.last;

endmodule

@@ sv/bsst_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the bounded signed score table, bound to the top level.
// Depends on bsst_pkg for outcome codes.
module bsst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import bsst_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new request taken while one is in flight");

   // a pending non-final trim result means the trim is still running
   a_busy_mid_trim: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken before trim finished");

   a_evkey_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != OC_TRIMMED && rsp_tuser != OC_CREATED_EV
      |-> rsp_tdata[15:0] == '0)
      else $error("evicted key set without eviction");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != OC_TRIMMED |-> rsp_tlast)
      else $error("non-trim result without last");

endmodule

bind bounded_signed_score_table bsst_checker u_bsst_checker (.*);

@@ test/tb_checker.sv @@
`timescale 1ns / 1ps
// Checker for the bounded signed score table: watches the request, result and
// register channels, predicts results and counts mismatches. Depends on bsst_pkg.
module tb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_results
);
   import bsst_pkg::*;

   localparam int DEPTH = 32;

   logic [15:0] tbl_key [DEPTH];
   int          tbl_score [DEPTH];
   int          tbl_count;
   int          lim_reg, vmax_reg, dmax_reg, owner_reg;
   result_type  expected_results [$];

   function automatic int sat(int v, int m);
      if (v > m) return m;
      if (v < -m) return -m;
      return v;
   endfunction

   function automatic int absval(int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic int limit_now();
      if (lim_reg == 0) return 1;
      if (lim_reg > DEPTH) return DEPTH;
      return lim_reg;
   endfunction

   function automatic int find_slot(int key);
      int i;
      i = 0;
      while (i < tbl_count && tbl_key[i] < key) i++;
      return i;
   endfunction

   function automatic int weakest_slot();
      int w;
      w = 0;
      for (int i = 1; i < tbl_count; i++)
         if (absval(tbl_score[i]) < absval(tbl_score[w])) w = i;
      return w;
   endfunction

   task automatic remove_slot(int idx);
      for (int i = idx; i + 1 < tbl_count; i++) begin
         tbl_key[i] = tbl_key[i + 1];
         tbl_score[i] = tbl_score[i + 1];
      end
      if (tbl_count > 0) tbl_count--;
   endtask

   task automatic insert_slot(int idx, int key, int score);
      for (int i = tbl_count; i > idx; i--) begin
         tbl_key[i] = tbl_key[i - 1];
         tbl_score[i] = tbl_score[i - 1];
      end
      tbl_key[idx] = key[15:0];
      tbl_score[idx] = score;
      tbl_count++;
   endtask

   task automatic push_result(logic [2:0] oc, int ev, int sc, logic lst);
      result_type r;
      r.outcome = oc;
      r.evicted_key = ev[15:0];
      r.score = sc[15:0];
      r.last = lst;
      expected_results.insert(expected_results.size(), r);
   endtask

   task automatic score_request(logic [1:0] kind, int key, int delta);
      int idx, w, d, nxt, v, ev, vm;
      logic [2:0] oc;
      vm = (vmax_reg == 0) ? 1 : vmax_reg;
      ev = 0;
      case (kind)
         REQ_ADD: begin
            d = sat(delta, (dmax_reg == 0) ? 1 : dmax_reg);
            idx = find_slot(key);
            if (key == 0 || key == owner_reg) oc = OC_INVALID;
            else if (idx < tbl_count && tbl_key[idx] == key) begin
               nxt = sat(tbl_score[idx] + d, vm);
               if (nxt == tbl_score[idx]) oc = OC_UNCHANGED;
               else if (nxt == 0) begin
                  remove_slot(idx);
                  oc = OC_REMOVED;
               end else begin
                  tbl_score[idx] = nxt;
                  oc = OC_UPDATED;
               end
            end else if (d == 0) oc = OC_UNCHANGED;
            else begin
               v = sat(d, vm);
               if (tbl_count >= limit_now()) begin
                  w = weakest_slot();
                  if (absval(v) <= absval(tbl_score[w])) oc = OC_DROPPED;
                  else begin
                     ev = tbl_key[w];
                     remove_slot(w);
                     if (w < idx) idx--;
                     insert_slot(idx, key, v);
                     oc = OC_CREATED_EV;
                  end
               end else begin
                  insert_slot(idx, key, v);
                  oc = OC_CREATED;
               end
            end
            push_result(oc, ev, 0, 1'b1);
         end
         REQ_LOOKUP: begin
            idx = find_slot(key);
            push_result(OC_UNCHANGED, 0,
                        (idx < tbl_count && tbl_key[idx] == key) ? tbl_score[idx] : 0, 1'b1);
         end
         REQ_TRIM: begin
            if (tbl_count <= limit_now()) push_result(OC_UNCHANGED, 0, 0, 1'b1);
            else
               while (tbl_count > limit_now()) begin
                  w = weakest_slot();
                  ev = tbl_key[w];
                  remove_slot(w);
                  push_result(OC_TRIMMED, ev, 0, tbl_count <= limit_now());
               end
         end
         default: push_result(OC_INVALID, 0, 0, 1'b1);
      endcase
   endtask

   assign pending_results = expected_results.size();

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         tbl_count = 0;
         lim_reg = 32;
         vmax_reg = 100;
         dmax_reg = 100;
         owner_reg = 0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready)
            case (csr_index)
               CSR_ENTRY_LIMIT: lim_reg = csr_wdata[5:0];
               CSR_VALUE_MAX:   vmax_reg = csr_wdata[14:0];
               CSR_DELTA_MAX:   dmax_reg = csr_wdata[14:0];
               default:         owner_reg = csr_wdata;
            endcase
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast};
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: outcome %0d ev %0d score %0d last %0b",
                           got.outcome, got.evicted_key, got.score, got.last);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                              want.outcome, want.evicted_key, want.score, want.last,
                              got.outcome, got.evicted_key, got.score, got.last);
               end
            end
         end
         if (req_tvalid && req_tready)
            score_request(req_tuser, req_tdata[15:0], $signed(req_tdata[31:16]));
      end
   end
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the bounded signed score table: drives requests and
// register writes, and gives the verdict from tb_checker. Depends on bsst_pkg.
module tb_top;
   import bsst_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending_results;
   int          cycle_count = 0;
   int          stall_mode = 0;
   int          burst_left = 0;

   // small key pool so adds hit existing entries and the table fills
   logic [15:0] key_pool [40];

   always #10 clock = ~clock;

   bounded_signed_score_table u_top (.*);

   tb_checker u_checker (.*);

   // watchdog: slowest run is well under this
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("** bounded_signed_score_table: FAILED **");
         $finish;
      end
   end

   // receiver: stall pattern switches at random among four modes
   always @(negedge clock) begin
      if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= (cycle_count % 8) < 3;
         default: rsp_tready <= ($urandom_range(0, 1) == 1);
      endcase
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold one request until it is taken; insert a gap at burst boundaries
   task automatic send_request(logic [1:0] kind, logic [15:0] key, logic [15:0] delta);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
      burst_left--;
      // wait for a falling edge so the previous drop of tvalid settles first
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {delta, key};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain_block();
      while (pending_results != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic random_phase(int count, int trim_pct);
      int pick;
      logic [15:0] key, delta;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         key = ($urandom_range(0, 9) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 39)];
         delta = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                             : 16'($signed($urandom_range(0, 400)) - 200);
         if (pick < trim_pct) send_request(REQ_TRIM, key, delta);
         else if (pick < trim_pct + 20) send_request(REQ_LOOKUP, key, delta);
         else if (pick < trim_pct + 22) send_request(REQ_RESERVED, key, delta);
         else send_request(REQ_ADD, key, delta);
      end
   endtask

   initial begin
      foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(1, 65535));
      key_pool[0] = 16'hFFFF;
      key_pool[1] = 16'h0001;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every request type, special cases
      send_request(REQ_TRIM, 16'h0005, 16'h0000);        // trim with nothing to evict
      send_request(REQ_ADD, 16'h0000, 16'h0010);         // key zero
      send_request(REQ_ADD, 16'h0005, 16'h0000);         // new key, zero delta
      send_request(REQ_ADD, 16'hFFFF, 16'h7FFF);         // clamp high
      send_request(REQ_ADD, 16'h0001, 16'h8000);         // clamp low
      send_request(REQ_ADD, 16'hFFFF, 16'h0001);         // saturated, unchanged
      send_request(REQ_ADD, 16'h0001, 16'h0064);         // reaches zero, removed
      send_request(REQ_ADD, 16'h1234, 16'h0005);
      send_request(REQ_ADD, 16'h1234, 16'hFFFE);         // update
      send_request(REQ_LOOKUP, 16'h1234, 16'h0000);
      send_request(REQ_LOOKUP, 16'h4321, 16'hFFFF);      // absent key
      send_request(REQ_LOOKUP, 16'h0000, 16'h0000);
      send_request(REQ_RESERVED, 16'hAAAA, 16'h5555);    // unused request type
      drain_block();

      // own id set, tiny limit: evict, drop, trim
      write_reg(CSR_OWN_ID, 16'hFFFF);
      write_reg(CSR_ENTRY_LIMIT, 16'd1);
      send_request(REQ_ADD, 16'hFFFF, 16'h0001);         // owner key is invalid
      send_request(REQ_ADD, 16'h0002, 16'h0001);         // weaker than stored: dropped
      send_request(REQ_ADD, 16'h0003, 16'h0050);         // stronger: evicts
      send_request(REQ_TRIM, 16'h0000, 16'h0000);
      drain_block();

      // zero magnitudes act as one; limit zero acts as one
      write_reg(CSR_ENTRY_LIMIT, 16'd0);
      write_reg(CSR_VALUE_MAX, 16'd0);
      write_reg(CSR_DELTA_MAX, 16'd0);
      random_phase(20, 5);
      drain_block();

      // maximum magnitudes, limit above table size
      write_reg(CSR_ENTRY_LIMIT, 16'd63);
      write_reg(CSR_VALUE_MAX, 16'h7FFF);
      write_reg(CSR_DELTA_MAX, 16'h7FFF);
      write_reg(CSR_OWN_ID, key_pool[5]);
      random_phase(40, 3);
      drain_block();

      // shrink the limit to force long trims
      write_reg(CSR_ENTRY_LIMIT, 16'd2);
      write_reg(CSR_VALUE_MAX, 16'd150);
      write_reg(CSR_DELTA_MAX, 16'd60);
      random_phase(40, 15);
      drain_block();

      write_reg(CSR_ENTRY_LIMIT, 16'd32);
      write_reg(CSR_VALUE_MAX, 16'd100);
      write_reg(CSR_DELTA_MAX, 16'd100);
      write_reg(CSR_OWN_ID, 16'h0000);
      random_phase(40, 4);
      drain_block();

      if (fail_count == 0 && pending_results == 0)
         $display("** bounded_signed_score_table: PASSED **");
      else
         $display("** bounded_signed_score_table: FAILED **");
      $finish;
   end
endmodule
